// ----- design/hpfm_pkg.sv -----
// ----------------------------------------------------------------------------
// hpfm_pkg - shared types and constants for the perigee to four-momentum core
// Widths, CORDIC tables, status codes and the stage records passed between
// the pipeline sections.
// ----------------------------------------------------------------------------
package hpfm_pkg;

   localparam int CORDIC_ITERATIONS = 20;
   localparam int CORDIC_STEPS = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;

   localparam int PT_W   = 36;
   localparam int KMAG_W = 32;
   localparam int CX_W   = 34;
   localparam int CZ_W   = 36;
   localparam int TRIG_W = 28;
   localparam int PZ_Q_W = 39;
   localparam int ST_W   = 26;
   localparam int ROOT_W = 42;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int SQ_W   = 82;

   localparam logic signed [CZ_W-1:0] Q30_PI      = 36'sd3373259426;
   localparam logic signed [CZ_W-1:0] Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [CX_W-1:0] Q30_GAIN    = 34'sd652032874;
   localparam logic signed [CX_W-1:0] CORDIC_RND  = 34'sd32;
   localparam logic [38:0] LIM39 = '1;

   localparam logic [19:0] FIELD_RESET = 20'd131072;
   localparam logic [23:0] CONV_RESET  = 24'd5029646;

   localparam logic [7:0] CSR_FIELD_STRENGTH    = 8'd0;
   localparam logic [7:0] CSR_CONVERSION_FACTOR = 8'd1;

   localparam logic [31:0] ATAN_Q30 [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_CURV = 2'd1,
      STATUS_SAT       = 2'd2
   } status_type;

   typedef struct packed {
      logic [17:0]        polar_angle;
      logic signed [18:0] azimuth;
      logic signed [31:0] curvature;
      logic [31:0]        particle_mass;
   } track_type;

   typedef struct packed {
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      logic signed [CZ_W-1:0] z;
      logic                   flip;
   } cordic_type;

   typedef struct packed {
      logic              valid;
      logic              kzero;
      logic [31:0]       mass;
      logic [KMAG_W-1:0] den;
      logic [KMAG_W-1:0] rem;
      logic [PT_W-1:0]   num;
      logic [PT_W-1:0]   quo;
      cordic_type        phi;
      cordic_type        theta;
   } front_type;

   typedef struct packed {
      logic               valid;
      logic               kzero;
      logic               sat;
      logic signed [39:0] px;
      logic signed [39:0] py;
      logic signed [39:0] pz;
      logic [31:0]        mass;
   } mid_type;

   typedef struct packed {
      logic signed [39:0] px;
      logic signed [39:0] py;
      logic signed [39:0] pz;
      logic [38:0]        energy;
      status_type         status;
   } rsp_type;

   function automatic cordic_type cordic_init(input logic signed [18:0] ang);
      cordic_type c;
      logic signed [CZ_W-1:0] z;
      z = $signed({{(CZ_W-33){ang[18]}}, ang, 14'b0});
      c.x = Q30_GAIN;
      c.y = '0;
      c.z = z;
      c.flip = 1'b0;
      if (z > Q30_HALF_PI) begin
         c.z = z - Q30_PI;
         c.flip = 1'b1;
      end else if (z < -Q30_HALF_PI) begin
         c.z = z + Q30_PI;
         c.flip = 1'b1;
      end
      return c;
   endfunction

   function automatic cordic_type cordic_step(input cordic_type c, input int i);
      cordic_type r;
      logic signed [CX_W-1:0] dx;
      logic signed [CX_W-1:0] dy;
      logic signed [CZ_W-1:0] a;
      dx = $signed(c.x) >>> i;
      dy = $signed(c.y) >>> i;
      a = $signed({{(CZ_W-32){1'b0}}, ATAN_Q30[i]});
      r.flip = c.flip;
      if (!c.z[CZ_W-1]) begin
         r.x = c.x - dy;
         r.y = c.y + dx;
         r.z = c.z - a;
      end else begin
         r.x = c.x + dy;
         r.y = c.y - dx;
         r.z = c.z + a;
      end
      return r;
   endfunction

   function automatic logic signed [TRIG_W-1:0] cordic_round(
      input logic signed [CX_W-1:0] v, input logic flip);
      logic signed [CX_W-1:0] s;
      logic signed [CX_W-1:0] t;
      s = flip ? -v : v;
      t = (s + CORDIC_RND) >>> 6;
      return t[TRIG_W-1:0];
   endfunction

endpackage

// ----- design/hpfm_if.sv -----
// ----------------------------------------------------------------------------
// hpfm_if - channel interfaces of the perigee to four-momentum core
// Track beats in, four-momentum beats out, register writes.
// ----------------------------------------------------------------------------
interface hpfm_req_if;
   logic               valid;
   logic               ready;
   logic [17:0]        polar_angle;
   logic signed [18:0] azimuth;
   logic signed [31:0] curvature;
   logic [31:0]        particle_mass;

   modport source (output valid, polar_angle, azimuth, curvature, particle_mass,
                   input ready);
   modport sink (input valid, polar_angle, azimuth, curvature, particle_mass,
                 output ready);
endinterface

interface hpfm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [39:0] px;
   logic signed [39:0] py;
   logic signed [39:0] pz;
   logic [38:0]        energy;
   logic [1:0]         status;

   modport source (output valid, px, py, pz, energy, status, input ready);
   modport sink (input valid, px, py, pz, energy, status, output ready);
endinterface

interface hpfm_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [23:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- design/hpfm_front.sv -----
// ----------------------------------------------------------------------------
// hpfm_front - pt divider and angle CORDICs
// One quotient bit of pt in every stage, and one CORDIC iteration per angle in each of the first CORDIC_STEPS stages.
// ----------------------------------------------------------------------------
module hpfm_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  hpfm_pkg::track_type  in_track,
   input  logic [19:0]          field_strength,
   input  logic [23:0]          conversion_factor,
   output hpfm_pkg::front_type  out_stage
);

   hpfm_pkg::front_type stage_ff [hpfm_pkg::PT_W+1];
   hpfm_pkg::front_type stage_in [hpfm_pkg::PT_W+1];

   logic [43:0] prod;

   always_comb begin
      prod = 44'(field_strength) * 44'(conversion_factor);
      stage_in[0].valid = in_valid;
      stage_in[0].kzero = (in_track.curvature == '0);
      stage_in[0].mass  = in_track.particle_mass;
      stage_in[0].den   = in_track.curvature[31] ? 32'(-in_track.curvature)
                                                 : 32'(in_track.curvature);
      stage_in[0].rem   = '0;
      stage_in[0].num   = prod[43:8];
      stage_in[0].quo   = '0;
      stage_in[0].phi   = hpfm_pkg::cordic_init(in_track.azimuth);
      stage_in[0].theta = hpfm_pkg::cordic_init($signed({1'b0, in_track.polar_angle}));
   end

   for (genvar g = 1; g <= hpfm_pkg::PT_W; g++) begin : g_step
      logic [hpfm_pkg::KMAG_W:0] sh;
      logic [hpfm_pkg::KMAG_W:0] diff;
      logic                      ge;

      always_comb begin
         sh   = {stage_ff[g-1].rem, stage_ff[g-1].num[hpfm_pkg::PT_W-1]};
         diff = sh - {1'b0, stage_ff[g-1].den};
         ge   = (sh >= {1'b0, stage_ff[g-1].den});
         stage_in[g] = stage_ff[g-1];
         stage_in[g].rem = ge ? diff[hpfm_pkg::KMAG_W-1:0] : sh[hpfm_pkg::KMAG_W-1:0];
         stage_in[g].num = {stage_ff[g-1].num[hpfm_pkg::PT_W-2:0], 1'b0};
         stage_in[g].quo = {stage_ff[g-1].quo[hpfm_pkg::PT_W-2:0], ge};
         if (g - 1 < hpfm_pkg::CORDIC_STEPS) begin
            stage_in[g].phi   = hpfm_pkg::cordic_step(stage_ff[g-1].phi, g - 1);
            stage_in[g].theta = hpfm_pkg::cordic_step(stage_ff[g-1].theta, g - 1);
         end
      end
   end

   for (genvar g = 0; g <= hpfm_pkg::PT_W; g++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[g].valid <= 1'b0;
         end else if (en) begin
            stage_ff[g] <= stage_in[g];
         end
      end
   end

   assign out_stage = stage_ff[hpfm_pkg::PT_W];

endmodule

// ----- design/hpfm_mid.sv -----
// ----------------------------------------------------------------------------
// hpfm_mid - trig rounding, momentum products and pz divider
// Split products, then one quotient bit of pz per stage with saturation.
// ----------------------------------------------------------------------------
module hpfm_mid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  hpfm_pkg::front_type  in_stage,
   output hpfm_pkg::mid_type    out_stage
);

   typedef struct packed {
      logic                                valid;
      logic                                kzero;
      logic [31:0]                         mass;
      logic [hpfm_pkg::PT_W-1:0]           pt;
      logic signed [hpfm_pkg::TRIG_W-1:0]  cp;
      logic signed [hpfm_pkg::TRIG_W-1:0]  sp;
      logic signed [hpfm_pkg::TRIG_W-1:0]  ct;
      logic signed [hpfm_pkg::TRIG_W-1:0]  st;
   } trig_type;

   typedef struct packed {
      logic                                valid;
      logic                                kzero;
      logic [31:0]                         mass;
      logic signed [46:0]                  px_lo;
      logic signed [46:0]                  px_hi;
      logic signed [46:0]                  py_lo;
      logic signed [46:0]                  py_hi;
      logic signed [46:0]                  pz_lo;
      logic signed [46:0]                  pz_hi;
      logic signed [hpfm_pkg::TRIG_W-1:0]  st;
   } mul_type;

   typedef struct packed {
      logic                                valid;
      logic                                kzero;
      logic [31:0]                         mass;
      logic signed [39:0]                  px;
      logic signed [39:0]                  py;
      logic signed [63:0]                  num;
      logic signed [hpfm_pkg::TRIG_W-1:0]  st;
   } sum_type;

   typedef struct packed {
      logic                        valid;
      logic                        kzero;
      logic [31:0]                 mass;
      logic signed [39:0]          px;
      logic signed [39:0]          py;
      logic                        qneg;
      logic                        numneg;
      logic                        numzero;
      logic                        stzero;
      logic                        ovf;
      logic [hpfm_pkg::ST_W-1:0]   den;
      logic [hpfm_pkg::ST_W-1:0]   rem;
      logic [hpfm_pkg::PZ_Q_W-1:0] dvd;
      logic [hpfm_pkg::PZ_Q_W-1:0] quo;
   } div_type;

   trig_type trig_ff, trig_in;
   mul_type  mul_ff, mul_in;
   sum_type  sum_ff, sum_in;
   div_type  div_ff [hpfm_pkg::PZ_Q_W+1];
   div_type  div_in [hpfm_pkg::PZ_Q_W+1];
   hpfm_pkg::mid_type out_ff, out_in;

   logic signed [18:0] pt_lo;
   logic signed [18:0] pt_hi;
   logic signed [65:0] px_full;
   logic signed [65:0] py_full;
   logic signed [65:0] pz_full;
   logic [63:0]        num_mag;
   logic [hpfm_pkg::ST_W-1:0] st_mag;
   logic signed [39:0] lim40;
   logic [39:0]        qext;

   always_comb begin
      trig_in.valid = in_stage.valid;
      trig_in.kzero = in_stage.kzero;
      trig_in.mass  = in_stage.mass;
      trig_in.pt    = in_stage.quo;
      trig_in.cp    = hpfm_pkg::cordic_round(in_stage.phi.x, in_stage.phi.flip);
      trig_in.sp    = hpfm_pkg::cordic_round(in_stage.phi.y, in_stage.phi.flip);
      trig_in.ct    = hpfm_pkg::cordic_round(in_stage.theta.x, in_stage.theta.flip);
      trig_in.st    = hpfm_pkg::cordic_round(in_stage.theta.y, in_stage.theta.flip);
   end

   always_comb begin
      pt_lo = $signed({1'b0, trig_ff.pt[17:0]});
      pt_hi = $signed({1'b0, trig_ff.pt[35:18]});
      mul_in.valid = trig_ff.valid;
      mul_in.kzero = trig_ff.kzero;
      mul_in.mass  = trig_ff.mass;
      mul_in.px_lo = pt_lo * trig_ff.cp;
      mul_in.px_hi = pt_hi * trig_ff.cp;
      mul_in.py_lo = pt_lo * trig_ff.sp;
      mul_in.py_hi = pt_hi * trig_ff.sp;
      mul_in.pz_lo = pt_lo * trig_ff.ct;
      mul_in.pz_hi = pt_hi * trig_ff.ct;
      mul_in.st    = trig_ff.st;
   end

   always_comb begin
      px_full = ($signed(66'(mul_ff.px_hi)) <<< 18) + 66'(mul_ff.px_lo);
      py_full = ($signed(66'(mul_ff.py_hi)) <<< 18) + 66'(mul_ff.py_lo);
      pz_full = ($signed(66'(mul_ff.pz_hi)) <<< 18) + 66'(mul_ff.pz_lo);
      sum_in.valid = mul_ff.valid;
      sum_in.kzero = mul_ff.kzero;
      sum_in.mass  = mul_ff.mass;
      sum_in.px    = 40'(px_full >>> 24);
      sum_in.py    = 40'(py_full >>> 24);
      sum_in.num   = 64'(pz_full);
      sum_in.st    = mul_ff.st;
   end

   always_comb begin
      num_mag = sum_ff.num[63] ? 64'(-sum_ff.num) : 64'(sum_ff.num);
      st_mag  = sum_ff.st[hpfm_pkg::TRIG_W-1] ? hpfm_pkg::ST_W'(-sum_ff.st)
                                              : hpfm_pkg::ST_W'(sum_ff.st);
      div_in[0].valid   = sum_ff.valid;
      div_in[0].kzero   = sum_ff.kzero;
      div_in[0].mass    = sum_ff.mass;
      div_in[0].px      = sum_ff.px;
      div_in[0].py      = sum_ff.py;
      div_in[0].numneg  = sum_ff.num[63];
      div_in[0].numzero = (sum_ff.num == '0);
      div_in[0].stzero  = (sum_ff.st == '0);
      div_in[0].qneg    = sum_ff.num[63] ^ sum_ff.st[hpfm_pkg::TRIG_W-1];
      div_in[0].ovf     = ({1'b0, num_mag} >= {st_mag, 39'b0});
      div_in[0].den     = st_mag;
      div_in[0].rem     = hpfm_pkg::ST_W'(num_mag[63:hpfm_pkg::PZ_Q_W]);
      div_in[0].dvd     = num_mag[hpfm_pkg::PZ_Q_W-1:0];
      div_in[0].quo     = '0;
   end

   for (genvar g = 1; g <= hpfm_pkg::PZ_Q_W; g++) begin : g_div
      logic [hpfm_pkg::ST_W:0] sh;
      logic [hpfm_pkg::ST_W:0] diff;
      logic                    ge;

      always_comb begin
         sh   = {div_ff[g-1].rem, div_ff[g-1].dvd[hpfm_pkg::PZ_Q_W-1]};
         diff = sh - {1'b0, div_ff[g-1].den};
         ge   = (sh >= {1'b0, div_ff[g-1].den});
         div_in[g] = div_ff[g-1];
         div_in[g].rem = ge ? diff[hpfm_pkg::ST_W-1:0] : sh[hpfm_pkg::ST_W-1:0];
         div_in[g].dvd = {div_ff[g-1].dvd[hpfm_pkg::PZ_Q_W-2:0], 1'b0};
         div_in[g].quo = {div_ff[g-1].quo[hpfm_pkg::PZ_Q_W-2:0], ge};
      end
   end

   always_comb begin
      lim40 = $signed({1'b0, hpfm_pkg::LIM39});
      qext  = {1'b0, div_ff[hpfm_pkg::PZ_Q_W].quo};
      out_in.valid = div_ff[hpfm_pkg::PZ_Q_W].valid;
      out_in.kzero = div_ff[hpfm_pkg::PZ_Q_W].kzero;
      out_in.mass  = div_ff[hpfm_pkg::PZ_Q_W].mass;
      out_in.px    = div_ff[hpfm_pkg::PZ_Q_W].px;
      out_in.py    = div_ff[hpfm_pkg::PZ_Q_W].py;
      if (div_ff[hpfm_pkg::PZ_Q_W].stzero) begin
         out_in.sat = !div_ff[hpfm_pkg::PZ_Q_W].numzero;
         if (div_ff[hpfm_pkg::PZ_Q_W].numzero) begin
            out_in.pz = '0;
         end else begin
            out_in.pz = div_ff[hpfm_pkg::PZ_Q_W].numneg ? -lim40 : lim40;
         end
      end else if (div_ff[hpfm_pkg::PZ_Q_W].ovf) begin
         out_in.sat = 1'b1;
         out_in.pz  = div_ff[hpfm_pkg::PZ_Q_W].qneg ? -lim40 : lim40;
      end else begin
         out_in.sat = 1'b0;
         out_in.pz  = div_ff[hpfm_pkg::PZ_Q_W].qneg ? $signed(-qext) : $signed(qext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff.valid <= 1'b0;
         mul_ff.valid  <= 1'b0;
         sum_ff.valid  <= 1'b0;
         out_ff.valid  <= 1'b0;
      end else if (en) begin
         trig_ff <= trig_in;
         mul_ff  <= mul_in;
         sum_ff  <= sum_in;
         out_ff  <= out_in;
      end
   end

   for (genvar g = 0; g <= hpfm_pkg::PZ_Q_W; g++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[g].valid <= 1'b0;
         end else if (en) begin
            div_ff[g] <= div_in[g];
         end
      end
   end

   assign out_stage = out_ff;

endmodule

// ----- design/hpfm_energy.sv -----
// ----------------------------------------------------------------------------
// hpfm_energy - squared momentum sum and integer square root
// Split squares, adder tree, then one root bit per stage; output register.
// ----------------------------------------------------------------------------
module hpfm_energy (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  hpfm_pkg::mid_type  in_stage,
   output logic               out_valid,
   output hpfm_pkg::rsp_type  out_rsp
);

   typedef struct packed {
      logic               valid;
      logic               kzero;
      logic               sat;
      logic signed [39:0] px;
      logic signed [39:0] py;
      logic signed [39:0] pz;
   } tag_type;

   typedef struct packed {
      tag_type         tag;
      logic [2:0][39:0] hh;
      logic [2:0][39:0] hl;
      logic [2:0][39:0] ll;
      logic [63:0]      mm;
   } sq1_type;

   typedef struct packed {
      tag_type                         tag;
      logic [2:0][hpfm_pkg::SQ_W-1:0]  sq;
      logic [63:0]                     mm;
   } sq2_type;

   typedef struct packed {
      tag_type                   tag;
      logic [hpfm_pkg::SQ_W:0]   a;
      logic [hpfm_pkg::SQ_W:0]   b;
   } sq3_type;

   typedef struct packed {
      tag_type                     tag;
      logic [hpfm_pkg::RAD_W-1:0]  rad;
      logic [hpfm_pkg::ROOT_W+1:0] rem;
      logic [hpfm_pkg::ROOT_W-1:0] root;
   } root_type;

   sq1_type  sq1_ff, sq1_in;
   sq2_type  sq2_ff, sq2_in;
   sq3_type  sq3_ff, sq3_in;
   root_type root_ff [hpfm_pkg::ROOT_W+1];
   root_type root_in [hpfm_pkg::ROOT_W+1];
   logic               valid_ff;
   hpfm_pkg::rsp_type  rsp_ff, rsp_in;

   logic [2:0][39:0] mag;
   tag_type          last_tag;
   logic [hpfm_pkg::ROOT_W-1:0] root_last;
   logic             esat;

   always_comb begin
      mag[0] = in_stage.px[39] ? 40'(-in_stage.px) : 40'(in_stage.px);
      mag[1] = in_stage.py[39] ? 40'(-in_stage.py) : 40'(in_stage.py);
      mag[2] = in_stage.pz[39] ? 40'(-in_stage.pz) : 40'(in_stage.pz);
      sq1_in.tag.valid = in_stage.valid;
      sq1_in.tag.kzero = in_stage.kzero;
      sq1_in.tag.sat   = in_stage.sat;
      sq1_in.tag.px    = in_stage.px;
      sq1_in.tag.py    = in_stage.py;
      sq1_in.tag.pz    = in_stage.pz;
      for (int i = 0; i < 3; i++) begin
         sq1_in.hh[i] = 40'(mag[i][39:20]) * 40'(mag[i][39:20]);
         sq1_in.hl[i] = 40'(mag[i][39:20]) * 40'(mag[i][19:0]);
         sq1_in.ll[i] = 40'(mag[i][19:0]) * 40'(mag[i][19:0]);
      end
      sq1_in.mm = 64'(in_stage.mass) * 64'(in_stage.mass);
   end

   always_comb begin
      sq2_in.tag = sq1_ff.tag;
      sq2_in.mm  = sq1_ff.mm;
      for (int i = 0; i < 3; i++) begin
         sq2_in.sq[i] = hpfm_pkg::SQ_W'({sq1_ff.hh[i], 40'b0})
                      + hpfm_pkg::SQ_W'({sq1_ff.hl[i], 21'b0})
                      + hpfm_pkg::SQ_W'(sq1_ff.ll[i]);
      end
   end

   always_comb begin
      sq3_in.tag = sq2_ff.tag;
      sq3_in.a   = (hpfm_pkg::SQ_W+1)'(sq2_ff.sq[0]) + (hpfm_pkg::SQ_W+1)'(sq2_ff.sq[1]);
      sq3_in.b   = (hpfm_pkg::SQ_W+1)'(sq2_ff.sq[2]) + (hpfm_pkg::SQ_W+1)'(sq2_ff.mm);
   end

   always_comb begin
      root_in[0].tag  = sq3_ff.tag;
      root_in[0].rad  = hpfm_pkg::RAD_W'(sq3_ff.a) + hpfm_pkg::RAD_W'(sq3_ff.b);
      root_in[0].rem  = '0;
      root_in[0].root = '0;
   end

   for (genvar g = 1; g <= hpfm_pkg::ROOT_W; g++) begin : g_root
      logic [hpfm_pkg::ROOT_W+2:0] sh;
      logic [hpfm_pkg::ROOT_W+2:0] trial;
      logic [hpfm_pkg::ROOT_W+2:0] diff;
      logic                        ge;

      always_comb begin
         sh    = {root_ff[g-1].rem[hpfm_pkg::ROOT_W:0],
                  root_ff[g-1].rad[hpfm_pkg::RAD_W-1 -: 2]};
         trial = {1'b0, root_ff[g-1].root, 2'b01};
         diff  = sh - trial;
         ge    = (sh >= trial);
         root_in[g] = root_ff[g-1];
         root_in[g].rad  = {root_ff[g-1].rad[hpfm_pkg::RAD_W-3:0], 2'b00};
         root_in[g].rem  = ge ? diff[hpfm_pkg::ROOT_W+1:0] : sh[hpfm_pkg::ROOT_W+1:0];
         root_in[g].root = {root_ff[g-1].root[hpfm_pkg::ROOT_W-2:0], ge};
      end
   end

   always_comb begin
      last_tag  = root_ff[hpfm_pkg::ROOT_W].tag;
      root_last = root_ff[hpfm_pkg::ROOT_W].root;
      esat      = (root_last > hpfm_pkg::ROOT_W'(hpfm_pkg::LIM39));
      if (last_tag.kzero) begin
         rsp_in.px     = '0;
         rsp_in.py     = '0;
         rsp_in.pz     = '0;
         rsp_in.energy = '0;
         rsp_in.status = hpfm_pkg::STATUS_ZERO_CURV;
      end else begin
         rsp_in.px     = last_tag.px;
         rsp_in.py     = last_tag.py;
         rsp_in.pz     = last_tag.pz;
         rsp_in.energy = esat ? hpfm_pkg::LIM39 : root_last[38:0];
         rsp_in.status = (last_tag.sat || esat) ? hpfm_pkg::STATUS_SAT
                                                : hpfm_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq1_ff.tag.valid <= 1'b0;
         sq2_ff.tag.valid <= 1'b0;
         sq3_ff.tag.valid <= 1'b0;
         valid_ff         <= 1'b0;
      end else if (en) begin
         sq1_ff   <= sq1_in;
         sq2_ff   <= sq2_in;
         sq3_ff   <= sq3_in;
         valid_ff <= last_tag.valid;
         rsp_ff   <= rsp_in;
      end
   end

   for (genvar g = 0; g <= hpfm_pkg::ROOT_W; g++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            root_ff[g].tag.valid <= 1'b0;
         end else if (en) begin
            root_ff[g] <= root_in[g];
         end
      end
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

// ----- design/helix_perigee_to_four_momentum_core.sv -----
// ----------------------------------------------------------------------------
// helix_perigee_to_four_momentum_core - track perigee to four-momentum
// Converts theta, phi, curvature and mass to px, py, pz and energy.
//
//   channel  dir  beat
//   req_ch   in   polar_angle, azimuth, curvature, particle_mass
//   rsp_ch   out  px, py, pz, energy, status
//   csr_ch   in   index, data (0 field_strength, 1 conversion_factor)
//
// One track per cycle while rsp_ch is not stalled; the pipeline holds the pt divider (36 stages),
// the pz divider (39 stages) and the square root (42 stages).
// Reset clears all valid bits and loads the register defaults.
// A result held on rsp_ch freezes every stage together; nothing is dropped.
// ----------------------------------------------------------------------------
module helix_perigee_to_four_momentum_core (
   input  logic        clock,
   input  logic        reset,
   hpfm_req_if.sink    req_ch,
   hpfm_rsp_if.source  rsp_ch,
   hpfm_csr_if.sink    csr_ch
);

   logic [19:0] field_ff;
   logic [23:0] conv_ff;
   logic        en;

   hpfm_pkg::track_type track;
   hpfm_pkg::front_type front_out;
   hpfm_pkg::mid_type   mid_out;
   hpfm_pkg::rsp_type   rsp;
   logic                rsp_valid;
   logic [39:0]         pz_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff <= hpfm_pkg::FIELD_RESET;
         conv_ff  <= hpfm_pkg::CONV_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            hpfm_pkg::CSR_FIELD_STRENGTH:    field_ff <= csr_ch.data[19:0];
            hpfm_pkg::CSR_CONVERSION_FACTOR: conv_ff  <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;
   assign en           = !rsp_valid || rsp_ch.ready;
   assign req_ch.ready = en;

   assign track.polar_angle   = req_ch.polar_angle;
   assign track.azimuth       = req_ch.azimuth;
   assign track.curvature     = req_ch.curvature;
   assign track.particle_mass = req_ch.particle_mass;

   hpfm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .en                (en),
      .in_valid          (req_ch.valid),
      .in_track          (track),
      .field_strength    (field_ff),
      .conversion_factor (conv_ff),
      .out_stage         (front_out)
   );

   hpfm_mid u_mid (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_stage  (front_out),
      .out_stage (mid_out)
   );

   hpfm_energy u_energy (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_stage  (mid_out),
      .out_valid (rsp_valid),
      .out_rsp   (rsp)
   );

   assign rsp_ch.valid  = rsp_valid;
   assign rsp_ch.px     = rsp.px;
   assign rsp_ch.py     = rsp.py;
   assign rsp_ch.pz     = rsp.pz;
   assign rsp_ch.energy = rsp.energy;
   assign rsp_ch.status = rsp.status;

   assign pz_mag = rsp.pz[39] ? 40'(-rsp.pz) : 40'(rsp.pz);

   a_zero_curv_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == hpfm_pkg::STATUS_ZERO_CURV |->
         rsp.px == '0 && rsp.py == '0 && rsp.pz == '0 && rsp.energy == '0)
      else $error("zero curvature beat carries nonzero momentum");

   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == hpfm_pkg::STATUS_SAT |->
         rsp.energy == hpfm_pkg::LIM39 || pz_mag == {1'b0, hpfm_pkg::LIM39})
      else $error("saturated beat without a value at its bound");

   a_energy_covers_pz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp.energy} >= pz_mag)
      else $error("energy below |pz|");

endmodule
